@@ rtl/core/rth_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rth_pkg
// Shared types and constants of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rth_pkg;

  // Six hue sectors per turn, green and blue sectors start at these offsets
  localparam int unsigned HUE_SECTORS   = 6;
  localparam int unsigned HUE_OFS_GREEN = 2;
  localparam int unsigned HUE_OFS_BLUE  = 4;

  // Sector picked by the largest channel, ties go to red, then green
  typedef enum logic [2:0] {
    SEC_RED   = 3'b001,
    SEC_GREEN = 3'b010,
    SEC_BLUE  = 3'b100
  } rth_sector_e;

  // Per-item flags that travel with the divider operands
  typedef struct packed {
    logic grey;     // delta is zero, hue forced to zero
    logic black;    // max is zero, saturation forced to zero
    logic sat_int;  // integer bit of the saturation quotient
  } rth_flags_t;

endpackage

@@ rtl/core/rth_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rth_if
// Valid/ready stream interfaces for pixels in and HSV results out.
// ----------------------------------------------------------------------------
interface rth_pix_if #(
  parameter int unsigned CHAN_BITS = 8
);
  logic                 valid;
  logic                 ready;
  logic [CHAN_BITS-1:0] red;
  logic [CHAN_BITS-1:0] green;
  logic [CHAN_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_hsv_if #(
  parameter int unsigned CHAN_BITS = 8,
  parameter int unsigned FRAC_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS-1:0] hue;
  logic [FRAC_BITS:0]   saturation;
  logic [CHAN_BITS-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

@@ rtl/core/rth_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rth_front
// Two stages: max/min/sector search, then delta and divider operands.
// ----------------------------------------------------------------------------
module rth_front
  import rth_pkg::*;
#(
  parameter int unsigned CHAN_BITS = 8,
  parameter int unsigned DIV_BITS  = 11
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rth_pix_if.sink              pix_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output rth_flags_t           flags_o,
  output logic [CHAN_BITS-1:0] max_o,
  output logic [DIV_BITS-1:0]  hue_num_o,
  output logic [DIV_BITS-1:0]  hue_div_o,
  output logic [CHAN_BITS-1:0] sat_rem_o
);

  // Stage A: channel compare
  logic                 va_q;
  logic                 rdy_a, rdy_b;
  logic [CHAN_BITS-1:0] r_q, g_q, b_q, mx_q, mn_q;
  logic [CHAN_BITS-1:0] mx_d, mn_d;
  rth_sector_e          sec_q, sec_d;

  always_comb begin
    mx_d = pix_i.red;
    mn_d = pix_i.red;
    if (pix_i.green > mx_d) mx_d = pix_i.green;
    if (pix_i.blue > mx_d)  mx_d = pix_i.blue;
    if (pix_i.green < mn_d) mn_d = pix_i.green;
    if (pix_i.blue < mn_d)  mn_d = pix_i.blue;
    if (pix_i.red >= pix_i.green && pix_i.red >= pix_i.blue) begin
      sec_d = SEC_RED;
    end else if (pix_i.green >= pix_i.blue) begin
      sec_d = SEC_GREEN;
    end else begin
      sec_d = SEC_BLUE;
    end
  end

  assign rdy_a       = !va_q || rdy_b;
  assign pix_i.ready = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (rdy_a) begin
      va_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && pix_i.valid) begin
      r_q   <= pix_i.red;
      g_q   <= pix_i.green;
      b_q   <= pix_i.blue;
      mx_q  <= mx_d;
      mn_q  <= mn_d;
      sec_q <= sec_d;
    end
  end

  // Stage B: delta, hue numerator and divisor, saturation integer bit
  logic                 vb_q;
  logic [CHAN_BITS-1:0] delta;
  logic [DIV_BITS-1:0]  d_ext, r_ext, g_ext, b_ext;
  logic [DIV_BITS-1:0]  num_d, div_d;
  rth_flags_t           flags_d;

  assign delta = mx_q - mn_q;
  assign d_ext = DIV_BITS'(delta);
  assign r_ext = DIV_BITS'(r_q);
  assign g_ext = DIV_BITS'(g_q);
  assign b_ext = DIV_BITS'(b_q);
  assign div_d = DIV_BITS'(d_ext * DIV_BITS'(HUE_SECTORS));

  always_comb begin
    unique case (sec_q)
      SEC_RED: begin
        // wrap a negative red-sector result by a full turn
        if (g_q >= b_q) num_d = g_ext - b_ext;
        else            num_d = div_d + g_ext - b_ext;
      end
      SEC_GREEN: num_d = DIV_BITS'(d_ext * DIV_BITS'(HUE_OFS_GREEN)) + b_ext - r_ext;
      SEC_BLUE:  num_d = DIV_BITS'(d_ext * DIV_BITS'(HUE_OFS_BLUE)) + r_ext - g_ext;
      default:   num_d = '0;
    endcase
    flags_d.grey    = (delta == '0);
    flags_d.black   = (mx_q == '0);
    flags_d.sat_int = (delta == mx_q);
  end

  assign rdy_b = !vb_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (rdy_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && va_q) begin
      flags_o   <= flags_d;
      max_o     <= mx_q;
      hue_num_o <= num_d;
      hue_div_o <= div_d;
      sat_rem_o <= flags_d.sat_int ? '0 : delta;
    end
  end

  assign valid_o = vb_q;

endmodule

@@ rtl/core/rth_div_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rth_div_pipe
// Restoring divider pipeline, one quotient bit of hue and saturation a stage.
// ----------------------------------------------------------------------------
module rth_div_pipe
  import rth_pkg::*;
#(
  parameter int unsigned CHAN_BITS = 8,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DIV_BITS  = 11
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  rth_flags_t           flags_i,
  input  logic [CHAN_BITS-1:0] max_i,
  input  logic [DIV_BITS-1:0]  hue_num_i,
  input  logic [DIV_BITS-1:0]  hue_div_i,
  input  logic [CHAN_BITS-1:0] sat_rem_i,
  rth_hsv_if.source            hsv_o
);

  localparam int unsigned NS = FRAC_BITS;

  logic                 valid_q [NS];
  logic                 rdy     [NS+1];
  rth_flags_t           flg_q   [NS];
  logic [CHAN_BITS-1:0] mx_q    [NS];
  logic [DIV_BITS-1:0]  d6_q    [NS];
  logic [DIV_BITS-1:0]  hrem_q  [NS];
  logic [FRAC_BITS-1:0] hq_q    [NS];
  logic [CHAN_BITS-1:0] srem_q  [NS];
  logic [FRAC_BITS:0]   sq_q    [NS];

  assign rdy[NS] = hsv_o.ready;
  assign ready_o = rdy[0];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                 v_in;
    rth_flags_t           flg_in;
    logic [CHAN_BITS-1:0] mx_in, srem_in;
    logic [DIV_BITS-1:0]  d6_in, hrem_in;
    logic [FRAC_BITS-1:0] hq_in;
    logic [FRAC_BITS:0]   sq_in;
    logic [DIV_BITS:0]    ht;
    logic [CHAN_BITS:0]   st;
    logic                 hbit, sbit;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign flg_in  = flags_i;
      assign mx_in   = max_i;
      assign d6_in   = hue_div_i;
      assign hrem_in = hue_num_i;
      assign hq_in   = '0;
      assign srem_in = sat_rem_i;
      assign sq_in   = (FRAC_BITS+1)'(flags_i.sat_int);
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign flg_in  = flg_q[k-1];
      assign mx_in   = mx_q[k-1];
      assign d6_in   = d6_q[k-1];
      assign hrem_in = hrem_q[k-1];
      assign hq_in   = hq_q[k-1];
      assign srem_in = srem_q[k-1];
      assign sq_in   = sq_q[k-1];
    end

    // Shift the partial remainder, subtract the divisor where it fits
    assign ht   = {hrem_in, 1'b0};
    assign st   = {srem_in, 1'b0};
    assign hbit = (ht >= {1'b0, d6_in});
    assign sbit = (st >= {1'b0, mx_in});

    assign rdy[k] = !valid_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in) begin
        flg_q[k]  <= flg_in;
        mx_q[k]   <= mx_in;
        d6_q[k]   <= d6_in;
        hrem_q[k] <= hbit ? DIV_BITS'(ht - {1'b0, d6_in}) : DIV_BITS'(ht);
        hq_q[k]   <= {hq_in[FRAC_BITS-2:0], hbit};
        srem_q[k] <= sbit ? CHAN_BITS'(st - {1'b0, mx_in}) : CHAN_BITS'(st);
        sq_q[k]   <= {sq_in[FRAC_BITS-1:0], sbit};
      end
    end
  end

  // Drop the quotients of grey and black pixels
  assign hsv_o.valid      = valid_q[NS-1];
  assign hsv_o.hue        = flg_q[NS-1].grey  ? '0 : hq_q[NS-1];
  assign hsv_o.saturation = flg_q[NS-1].black ? '0 : sq_q[NS-1];
  assign hsv_o.brightness = mx_q[NS-1];

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] && !rdy[1] |=> valid_q[0] && $stable(hrem_q[0]) && $stable(sq_q[0]))
    else $error("stalled divider stage changed its item");

  a_hue_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[NS-1] && !flg_q[NS-1].grey |-> hrem_q[NS-1] < d6_q[NS-1])
    else $error("hue remainder not below divisor");

  a_sat_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[NS-1] && !flg_q[NS-1].black |-> srem_q[NS-1] < mx_q[NS-1])
    else $error("saturation remainder not below max");

endmodule

@@ rtl/core/rgb_to_hsv_convert.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert
// Pixel-rate RGB to HSV converter with a pipelined restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i carries one RGB pixel per item (valid/ready). hsv_o returns one
//   item per pixel, in order: hue as a 0.F fraction of a turn, saturation
//   as delta/max in 1.F format, brightness as the largest channel.
//   Items pass through the pipeline stages in order: one stage finds
//   max, min and sector, one forms delta and the divider operands, and each
//   of FRACTION_BITS divider stages resolves one quotient bit of hue and of
//   saturation side by side.
//   Throughput is one pixel per cycle while hsv_o.ready stays high; a
//   stage hands its item on as soon as the stage after it can take it.
//   Reset clears all stage valid bits, so the pipeline comes up empty; the
//   data registers are not reset.
//   When the receiver stalls, the output item holds and items behind it
//   keep moving into empty stages; pix_i.ready drops only once every stage
//   holds an item.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert
  import rth_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS  = 8,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rth_pix_if.sink   pix_i,
  rth_hsv_if.source hsv_o
);

  // Hue divisor is six times delta
  localparam int unsigned DIV_BITS = CHANNEL_BITS + $clog2(HUE_SECTORS);

  logic                    fr_valid, fr_ready;
  rth_flags_t              fr_flags;
  logic [CHANNEL_BITS-1:0] fr_max, fr_sat_rem;
  logic [DIV_BITS-1:0]     fr_hue_num, fr_hue_div;

  // Compare and operand stages
  rth_front #(
    .CHAN_BITS (CHANNEL_BITS),
    .DIV_BITS  (DIV_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_i),
    .valid_o   (fr_valid),
    .ready_i   (fr_ready),
    .flags_o   (fr_flags),
    .max_o     (fr_max),
    .hue_num_o (fr_hue_num),
    .hue_div_o (fr_hue_div),
    .sat_rem_o (fr_sat_rem)
  );

  // One quotient bit per stage, output register is the last stage
  rth_div_pipe #(
    .CHAN_BITS (CHANNEL_BITS),
    .FRAC_BITS (FRACTION_BITS),
    .DIV_BITS  (DIV_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (fr_valid),
    .ready_o   (fr_ready),
    .flags_i   (fr_flags),
    .max_i     (fr_max),
    .hue_num_i (fr_hue_num),
    .hue_div_i (fr_hue_div),
    .sat_rem_i (fr_sat_rem),
    .hsv_o     (hsv_o)
  );

endmodule
